// ----- src/lnti_pkg.sv -----
// Shared types and constants for the Lagrange node table interpolator.
package lnti_pkg;

   localparam int LNTI_MAX_NODES = 16;
   localparam int LNTI_X_BITS    = 12;

   localparam int X_COORD_W  = 12;
   localparam int VALUE_W    = 32;
   localparam int INDEX_W    = 4;
   localparam int TOTAL_W    = 5;
   localparam int STATUS_W   = 2;

   localparam logic KIND_TOGGLE = 1'b0;
   localparam logic KIND_EVAL   = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

   typedef struct packed {
      logic                      kind;
      logic [X_COORD_W-1:0]      x_coord;
      logic signed [VALUE_W-1:0] y_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] y_result;
      logic                      is_node;
      logic [INDEX_W-1:0]        node_index;
      logic [TOTAL_W-1:0]        node_total;
      logic [STATUS_W-1:0]       status;
   } rsp_type;

endpackage

// ----- src/lagrange_node_table_interpolator.sv -----
// Lagrange interpolator over a node table, one shared multiplier and a bit-serial divider.
// A toggle searches the table node by node, then appends the new node, or removes a found node
// by moving each later node down one slot. An evaluate does the same search; then each basis
// factor needs two multiplier passes, a clamp step and 64 steps of the one-bit-per-cycle divider.
// One word at a time; the next word is taken once the result is handed to the output register.
// Reset clears the node count and the handshake state; node store contents stay undefined.
module lagrange_node_table_interpolator #(
   parameter int MAX_NODES = lnti_pkg::LNTI_MAX_NODES,
   parameter int X_BITS    = lnti_pkg::LNTI_X_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lnti_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lnti_pkg::rsp_type rsp
);
   import lnti_pkg::*;

   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int IDX_W = $clog2(MAX_NODES);

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

   typedef enum logic [4:0] {
      S_IDLE, S_FRD, S_FCMP, S_FEND, S_SHRD, S_SHWR, S_APP,
      S_JRD, S_JGET, S_IRD, S_IGET, S_MLO, S_MHI, S_MFIN, S_DSET, S_DIV, S_DEND,
      S_THI, S_TLO, S_TSUM, S_TADD, S_DONE
   } state_type;

   state_type state_ff;

   logic [X_BITS-1:0]  node_x_mem [MAX_NODES];
   logic [VALUE_W-1:0] node_y_mem [MAX_NODES];
   logic [X_BITS-1:0]  x_rd_ff;
   logic [VALUE_W-1:0] y_rd_ff;

   logic [CNT_W-1:0] cnt_ff, scan_ff, match_ff, i_ff, j_ff;
   logic             kind_ff, found_ff, sat_ff, rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [X_BITS-1:0]  x_ff, xj_ff, mb_ff, dmag_ff, rem_ff;
   logic signed [VALUE_W-1:0] y_ff, yj_ff;
   logic signed [63:0] basis_ff, mul_ff, pl_ff, term_ff, sum_ff;
   logic [63:0]        ma_ff, dq_ff;
   logic               mneg_ff, den_neg_ff, qneg_ff;
   logic [5:0]         div_cnt_ff;
   rsp_type            rsp_ff;

   // memory ports
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic               mem_we;
   logic [X_BITS-1:0]  wr_x;
   logic [VALUE_W-1:0] wr_y;

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;

   // datapath helpers
   logic signed [X_BITS:0] num_s, den_s;
   logic [X_BITS-1:0]      num_mag, den_mag;
   logic [63:0]            basis_mag;
   logic [95:0]            wide_p;
   logic [X_BITS:0]        rem_sh;
   logic                   rem_ge;
   logic signed [64:0]     sum_ext;
   logic [CNT_W-1:0]       scan_nx, i_nx, j_nx;
   logic [CNT_W:0]         scan_nx2;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign scan_nx  = scan_ff + 1'b1;
   assign scan_nx2 = {1'b0, scan_nx} + 1'b1;
   assign i_nx     = i_ff + 1'b1;
   assign j_nx     = j_ff + 1'b1;

   assign num_s   = $signed({1'b0, x_ff}) - $signed({1'b0, x_rd_ff});
   assign den_s   = $signed({1'b0, xj_ff}) - $signed({1'b0, x_rd_ff});
   assign num_mag = num_s[X_BITS] ? X_BITS'(-num_s) : num_s[X_BITS-1:0];
   assign den_mag = den_s[X_BITS] ? X_BITS'(-den_s) : den_s[X_BITS-1:0];
   assign basis_mag = basis_ff[63] ? 64'(-basis_ff) : 64'(basis_ff);
   assign wide_p  = ({32'd0, 64'(mul_ff)} << 32) + {32'd0, 64'(pl_ff)};
   assign rem_sh  = {rem_ff, dq_ff[63]};
   assign rem_ge  = (rem_sh >= {1'b0, dmag_ff});
   assign sum_ext = {sum_ff[63], sum_ff} + {term_ff[63], term_ff};

   always_comb begin
      rd_addr = '0;
      mem_we  = 1'b0;
      wr_addr = scan_ff[IDX_W-1:0];
      wr_x    = x_rd_ff;
      wr_y    = y_rd_ff;
      mul_a   = '0;
      mul_b   = '0;
      case (state_ff)
         S_FRD:  rd_addr = scan_ff[IDX_W-1:0];
         S_SHRD: rd_addr = scan_nx[IDX_W-1:0];
         S_SHWR: mem_we  = 1'b1;
         S_APP: begin
            mem_we  = 1'b1;
            wr_addr = cnt_ff[IDX_W-1:0];
            wr_x    = x_ff;
            wr_y    = y_ff;
         end
         S_JRD:  rd_addr = j_ff[IDX_W-1:0];
         S_IRD:  rd_addr = i_ff[IDX_W-1:0];
         S_MLO: begin
            mul_a = $signed({1'b0, ma_ff[31:0]});
            mul_b = $signed(33'(mb_ff));
         end
         S_MHI: begin
            mul_a = $signed({1'b0, ma_ff[63:32]});
            mul_b = $signed(33'(mb_ff));
         end
         S_THI: begin
            mul_a = {yj_ff[31], yj_ff};
            mul_b = {basis_ff[63], basis_ff[63:32]};
         end
         S_TLO: begin
            mul_a = {yj_ff[31], yj_ff};
            mul_b = $signed({1'b0, basis_ff[31:0]});
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_x_mem[wr_addr] <= wr_x;
         node_y_mem[wr_addr] <= wr_y;
      end
      x_rd_ff <= node_x_mem[rd_addr];
      y_rd_ff <= node_y_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff   <= req.kind;
                  x_ff      <= X_BITS'(req.x_coord);
                  y_ff      <= req.y_value;
                  scan_ff   <= '0;
                  match_ff  <= '0;
                  found_ff  <= 1'b0;
                  sat_ff    <= 1'b0;
                  status_ff <= STATUS_OK;
                  sum_ff    <= '0;
                  state_ff  <= (cnt_ff == '0) ? S_FEND : S_FRD;
               end
            end
            S_FRD: state_ff <= S_FCMP;
            S_FCMP: begin
               if (x_rd_ff == x_ff) begin
                  found_ff <= 1'b1;
                  match_ff <= scan_ff;
                  state_ff <= S_FEND;
               end else if (scan_nx >= cnt_ff) begin
                  state_ff <= S_FEND;
               end else begin
                  scan_ff  <= scan_nx;
                  state_ff <= S_FRD;
               end
            end
            S_FEND: begin
               scan_ff <= match_ff;
               if (kind_ff == KIND_TOGGLE) begin
                  if (found_ff) begin
                     if (match_ff + 1'b1 < cnt_ff) begin
                        state_ff <= S_SHRD;
                     end else begin
                        cnt_ff   <= cnt_ff - 1'b1;
                        state_ff <= S_DONE;
                     end
                  end else if (cnt_ff < CNT_W'(MAX_NODES)) begin
                     state_ff <= S_APP;
                  end else begin
                     status_ff <= STATUS_FULL;
                     state_ff  <= S_DONE;
                  end
               end else begin
                  j_ff     <= '0;
                  state_ff <= (cnt_ff == '0) ? S_DONE : S_JRD;
               end
            end
            S_SHRD: state_ff <= S_SHWR;
            S_SHWR: begin
               // entry scan takes entry scan+1, walk until the last one moved
               scan_ff <= scan_nx;
               if (scan_nx2 < {1'b0, cnt_ff}) begin
                  state_ff <= S_SHRD;
               end else begin
                  cnt_ff   <= cnt_ff - 1'b1;
                  state_ff <= S_DONE;
               end
            end
            S_APP: begin
               cnt_ff   <= cnt_ff + 1'b1;
               state_ff <= S_DONE;
            end
            S_JRD: state_ff <= S_JGET;
            S_JGET: begin
               xj_ff    <= x_rd_ff;
               yj_ff    <= $signed(y_rd_ff);
               basis_ff <= 64'sh0000_0001_0000_0000;
               i_ff     <= '0;
               state_ff <= S_IRD;
            end
            S_IRD: begin
               if (i_ff == cnt_ff) begin
                  state_ff <= S_THI;
               end else if (i_ff == j_ff) begin
                  i_ff <= i_nx;
               end else begin
                  state_ff <= S_IGET;
               end
            end
            S_IGET: begin
               i_ff       <= i_nx;
               ma_ff      <= basis_mag;
               mb_ff      <= num_mag;
               mneg_ff    <= basis_ff[63] ^ num_s[X_BITS];
               dmag_ff    <= den_mag;
               den_neg_ff <= den_s[X_BITS];
               if (den_s == '0) begin
                  state_ff <= S_IRD;
               end else if (basis_ff == '0 || num_s == '0) begin
                  basis_ff <= '0;
                  state_ff <= S_IRD;
               end else begin
                  state_ff <= S_MLO;
               end
            end
            S_MLO: begin
               mul_ff   <= mul_p[63:0];
               state_ff <= S_MHI;
            end
            S_MHI: begin
               pl_ff    <= mul_ff;
               mul_ff   <= mul_p[63:0];
               state_ff <= S_MFIN;
            end
            S_MFIN: begin
               if (mneg_ff) begin
                  if (wide_p > 96'h8000_0000_0000_0000) begin
                     basis_ff <= S64_MIN;
                     sat_ff   <= 1'b1;
                  end else begin
                     basis_ff <= -$signed(wide_p[63:0]);
                  end
               end else if (wide_p[95:63] != '0) begin
                  basis_ff <= S64_MAX;
                  sat_ff   <= 1'b1;
               end else begin
                  basis_ff <= $signed(wide_p[63:0]);
               end
               state_ff <= S_DSET;
            end
            S_DSET: begin
               if (basis_ff == S64_MIN && den_neg_ff && dmag_ff == X_BITS'(1)) begin
                  basis_ff <= S64_MAX;
                  sat_ff   <= 1'b1;
                  state_ff <= S_IRD;
               end else begin
                  dq_ff      <= basis_mag;
                  rem_ff     <= '0;
                  qneg_ff    <= basis_ff[63] ^ den_neg_ff;
                  div_cnt_ff <= 6'd63;
                  state_ff   <= S_DIV;
               end
            end
            S_DIV: begin
               // restoring divide: quotient bits shift in as dividend bits shift out
               if (rem_ge) rem_ff <= X_BITS'(rem_sh - {1'b0, dmag_ff});
               else        rem_ff <= rem_sh[X_BITS-1:0];
               dq_ff      <= {dq_ff[62:0], rem_ge};
               div_cnt_ff <= div_cnt_ff - 1'b1;
               if (div_cnt_ff == '0) state_ff <= S_DEND;
            end
            S_DEND: begin
               basis_ff <= qneg_ff ? -$signed(dq_ff) : $signed(dq_ff);
               state_ff <= S_IRD;
            end
            S_THI: begin
               mul_ff   <= mul_p[63:0];
               state_ff <= S_TLO;
            end
            S_TLO: begin
               pl_ff    <= mul_ff;
               mul_ff   <= mul_p[63:0];
               state_ff <= S_TSUM;
            end
            S_TSUM: begin
               // y*hi + floor((y*lo) / 2^32)
               term_ff  <= pl_ff + (mul_ff >>> 32);
               state_ff <= S_TADD;
            end
            S_TADD: begin
               if (sum_ext[64] != sum_ext[63]) begin
                  sum_ff <= sum_ext[64] ? S64_MIN : S64_MAX;
                  sat_ff <= 1'b1;
               end else begin
                  sum_ff <= sum_ext[63:0];
               end
               j_ff     <= j_nx;
               state_ff <= (j_nx == cnt_ff) ? S_DONE : S_JRD;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.is_node     <= found_ff;
                  rsp_ff.node_index  <= found_ff ? INDEX_W'(match_ff) : '0;
                  rsp_ff.node_total  <= TOTAL_W'(cnt_ff);
                  if (sum_ff > S32_MAX) begin
                     rsp_ff.y_result <= S32_MAX[31:0];
                     rsp_ff.status   <= STATUS_SAT;
                  end else if (sum_ff < S32_MIN) begin
                     rsp_ff.y_result <= S32_MIN[31:0];
                     rsp_ff.status   <= STATUS_SAT;
                  end else begin
                     rsp_ff.y_result <= sum_ff[31:0];
                     rsp_ff.status   <= sat_ff ? STATUS_SAT : status_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_NODES))
      else $error("node count above table size");

   a_full_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STATUS_FULL |->
         rsp_ff.node_total == TOTAL_W'(MAX_NODES) && rsp_ff.y_result == '0 && !rsp_ff.is_node)
      else $error("full status with inconsistent result word");

   a_no_match_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.is_node |-> rsp_ff.node_index == '0)
      else $error("node index set without a match");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != S_IDLE)
      else $error("sequencer idle right after accepting a word");

endmodule
